FILE: src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// a stalled valid stays high and its payload holds
`define ASSERT_HOLD(label, vld, rdy, sig) \
  `ASSERT_RST(label, (vld && !rdy) |=> (vld && $stable(sig)))

`endif

FILE: src/lcdns_pkg.sv
// types, command codes and strobe tables for the lcd nibble sequencer
// no dependencies
package lcdns_pkg;

  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_INSTR  = 3'd1;
  localparam logic [2:0] CMD_DATA   = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_POS    = 3'd4;
  localparam logic [2:0] CMD_GLYPH  = 3'd5;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]  CLEAR_BYTE     = 8'h01;
  localparam logic [12:0] HOLD_US        = 13'd100;
  localparam logic [12:0] CLEAR_EXTRA_US = 13'd2000;
  localparam logic [3:0]  INIT_LAST_STEP = 4'd11;

  // one queued operation: either the init run or a single byte
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data_byte;
    logic       clear_hold;
  } op_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic [15:0] wait_before;
    logic        clear_hold;
  } strobe_t;

  // init run: wake-up nibbles, then 0x28, 0x0c, 0x06, 0x01
  function automatic strobe_t init_strobe(input logic [3:0] step);
    strobe_t s;
    s = '{nibble: 4'h0, wait_before: 16'd0, clear_hold: 1'b0};
    unique case (step)
      4'd0:    s = '{nibble: 4'h3, wait_before: 16'd50000, clear_hold: 1'b0};
      4'd1:    s = '{nibble: 4'h3, wait_before: 16'd4500,  clear_hold: 1'b0};
      4'd2:    s = '{nibble: 4'h3, wait_before: 16'd4500,  clear_hold: 1'b0};
      4'd3:    s = '{nibble: 4'h2, wait_before: 16'd150,   clear_hold: 1'b0};
      4'd4:    s.nibble = 4'h2;
      4'd5:    s.nibble = 4'h8;
      4'd6:    s.nibble = 4'h0;
      4'd7:    s.nibble = 4'hC;
      4'd8:    s.nibble = 4'h0;
      4'd9:    s.nibble = 4'h6;
      4'd10:   s.nibble = 4'h0;
      4'd11:   s = '{nibble: 4'h1, wait_before: 16'd0, clear_hold: 1'b1};
      default: s = '{nibble: 4'h0, wait_before: 16'd0, clear_hold: 1'b0};
    endcase
    return s;
  endfunction

endpackage

FILE: src/lcdns_front.sv
// front end: classifies display commands into queued operations
// depends on lcdns_pkg
module lcdns_front
  import lcdns_pkg::*;
(
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] command_i,
  input  logic [7:0] value_i,
  input  logic       row_i,
  input  logic [5:0] col_i,
  input  logic [2:0] glyph_slot_i,
  output logic       push_o,
  output op_t        push_op_o,
  input  logic       queue_full_i
);

  logic       cmd_ok;
  logic [6:0] ddram_addr;

  assign in_ready_o = !queue_full_i;
  assign ddram_addr = {row_i, 6'b0} + {1'b0, col_i};

  always_comb begin
    cmd_ok    = 1'b1;
    push_op_o = '{is_init: 1'b0, rs: 1'b0, data_byte: value_i, clear_hold: 1'b0};
    unique case (command_i)
      CMD_INIT:  push_op_o.is_init = 1'b1;
      CMD_INSTR: push_op_o.data_byte = value_i;
      CMD_DATA:  push_op_o.rs = 1'b1;
      CMD_CLEAR: begin
        push_op_o.data_byte  = CLEAR_BYTE;
        push_op_o.clear_hold = 1'b1;
      end
      CMD_POS:   push_op_o.data_byte = {1'b1, ddram_addr};
      CMD_GLYPH: push_op_o.data_byte = {2'b01, glyph_slot_i, 3'b000};
      // unused codes are taken and dropped
      default:   cmd_ok = 1'b0;
    endcase
  end

  assign push_o = in_valid_i && in_ready_o && cmd_ok;

endmodule

FILE: src/lcdns_queue.sv
// short operation queue between front and back end
// depends on lcdns_pkg
module lcdns_queue
  import lcdns_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  output logic valid_o,
  output op_t  head_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

FILE: src/lcdns_back.sv
// back end: steps the queue head through its strobes into the output register
// depends on lcdns_pkg
module lcdns_back
  import lcdns_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        op_valid_i,
  input  op_t         op_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        reg_select_o,
  output logic [3:0]  nibble_o,
  output logic [15:0] wait_before_us_o,
  output logic [12:0] wait_after_us_o,
  output logic        last_o
);

  logic        out_valid_q;
  logic [3:0]  step_q, step_d;
  logic        out_free, fire, strobe_last;
  strobe_t     init_s, cur_s;
  logic        rs_q;
  logic [3:0]  nibble_q;
  logic [15:0] wait_before_q;
  logic [12:0] wait_after_q;
  logic        last_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign fire     = op_valid_i && out_free;
  assign init_s   = init_strobe(step_q);

  always_comb begin
    if (op_i.is_init) begin
      cur_s       = init_s;
      strobe_last = (step_q == INIT_LAST_STEP);
    end else begin
      // high nibble on step 0, low nibble on step 1
      cur_s.nibble      = step_q[0] ? op_i.data_byte[3:0] : op_i.data_byte[7:4];
      cur_s.wait_before = 16'd0;
      cur_s.clear_hold  = op_i.clear_hold && step_q[0];
      strobe_last       = step_q[0];
    end
  end

  assign pop_o  = fire && strobe_last;
  assign step_d = pop_o ? 4'd0 : (fire ? step_q + 4'd1 : step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= 4'd0;
    end else begin
      step_q <= step_d;
      if (out_free) begin
        out_valid_q <= op_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rs_q          <= op_i.rs;
      nibble_q      <= cur_s.nibble;
      wait_before_q <= cur_s.wait_before;
      wait_after_q  <= cur_s.clear_hold ? HOLD_US + CLEAR_EXTRA_US : HOLD_US;
      last_q        <= strobe_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reg_select_o     = rs_q;
  assign nibble_o         = nibble_q;
  assign wait_before_us_o = wait_before_q;
  assign wait_after_us_o  = wait_after_q;
  assign last_o           = last_q;

endmodule

FILE: src/char_lcd_nibble_sequencer_top.sv
// top level of the character lcd 4-bit strobe sequencer
// depends on lcdns_pkg, lcdns_front, lcdns_queue, lcdns_back
//
// Expands each display command into 4-bit enable strobes, high nibble first:
// init gives 12 strobes, every other command 2, and codes 6 and 7 are
// accepted and give none. The back end produces one strobe per cycle from
// its step counter while the output is taken; while it works on a command
// the front end keeps taking commands each cycle as long as the operation
// queue (QueueDepth entries) has room. A strobe waits in the output register
// until taken; reset clears only the control state.
module char_lcd_nibble_sequencer_top
  import lcdns_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  value_i,
  input  logic        row_i,
  input  logic [5:0]  col_i,
  input  logic [2:0]  glyph_slot_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        reg_select_o,
  output logic [3:0]  nibble_o,
  output logic [15:0] wait_before_us_o,
  output logic [12:0] wait_after_us_o,
  output logic        last_o
);

  logic push, full, head_valid, pop;
  op_t  push_op, head_op;

  lcdns_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .value_i      (value_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .glyph_slot_i (glyph_slot_i),
    .push_o       (push),
    .push_op_o    (push_op),
    .queue_full_i (full)
  );

  lcdns_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .valid_o   (head_valid),
    .head_o    (head_op),
    .pop_i     (pop)
  );

  lcdns_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_valid_i       (head_valid),
    .op_i             (head_op),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .reg_select_o     (reg_select_o),
    .nibble_o         (nibble_o),
    .wait_before_us_o (wait_before_us_o),
    .wait_after_us_o  (wait_after_us_o),
    .last_o           (last_o)
  );

endmodule

FILE: src/lcdns_checker.sv
// port-level checks for the lcd nibble sequencer, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module lcdns_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  command_i,
  input logic [7:0]  value_i,
  input logic        row_i,
  input logic [5:0]  col_i,
  input logic [2:0]  glyph_slot_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        reg_select_o,
  input logic [3:0]  nibble_o,
  input logic [15:0] wait_before_us_o,
  input logic [12:0] wait_after_us_o,
  input logic        last_o
);

  logic [20:0] in_payload;
  logic [34:0] out_payload;
  assign in_payload  = {command_i, value_i, row_i, col_i, glyph_slot_i};
  assign out_payload = {reg_select_o, nibble_o, wait_before_us_o, wait_after_us_o, last_o};

  `ASSERT_HOLD(in_hold_a, in_valid_i, in_ready_o, in_payload)

  `ASSERT_HOLD(out_hold_a, out_valid_o, out_ready_i, out_payload)

  // data writes never carry long waits
  `ASSERT_RST(data_short_a, (out_valid_o && reg_select_o) |->
      (wait_before_us_o == 16'd0 && wait_after_us_o == 13'd100))

  // long pre-waits only on the wake-up nibbles
  `ASSERT_RST(wake_nib_a, (out_valid_o && wait_before_us_o != 16'd0) |->
      (!reg_select_o && !last_o && (nibble_o == 4'h3 || nibble_o == 4'h2)))

  // clear hold ends the transaction with the low nibble of the clear byte
  `ASSERT_RST(clear_hold_a, out_valid_o |->
      (wait_after_us_o == 13'd100 ||
       (wait_after_us_o == 13'd2100 && last_o && nibble_o == 4'h1)))

endmodule

bind char_lcd_nibble_sequencer_top lcdns_checker u_lcdns_checker (.*);

FILE: tb/tb_top.sv
// testbench for the character lcd 4-bit strobe sequencer
// depends on lcdns_pkg and char_lcd_nibble_sequencer_top; standalone, self-checking
`timescale 1ns / 1ps

module tb_top;
  import lcdns_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned RANDOM_OPS    = 45;

  localparam logic [15:0] WAKE_FIRST_US = 16'd50000;
  localparam logic [15:0] WAKE_NEXT_US  = 16'd4500;
  localparam logic [15:0] WAKE_LAST_US  = 16'd150;
  localparam logic [3:0]  WAKE_NIBBLE   = 4'h3;
  localparam logic [3:0]  MODE4_NIBBLE  = 4'h2;

  localparam logic [7:0] FUNC_SET_BYTE   = 8'h28;
  localparam logic [7:0] DISPLAY_ON_BYTE = 8'h0C;
  localparam logic [7:0] ENTRY_MODE_BYTE = 8'h06;
  localparam logic [7:0] SET_DDRAM_BIT   = 8'h80;
  localparam logic [7:0] SECOND_LINE     = 8'h40;
  localparam logic [7:0] SET_CGRAM_BIT   = 8'h40;

  // codes the block accepts and drops
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic [15:0] wait_before;
    logic [12:0] wait_after;
    logic        last;
  } lcd_strobe_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i    = '0;
  logic [7:0]  value_i      = '0;
  logic        row_i        = 1'b0;
  logic [5:0]  col_i        = '0;
  logic [2:0]  glyph_slot_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        reg_select_o;
  logic [3:0]  nibble_o;
  logic [15:0] wait_before_us_o;
  logic [12:0] wait_after_us_o;
  logic        last_o;

  lcd_strobe_t pending_strobes[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned in_idle_pct    = 0;
  int unsigned out_stall_pct  = 0;

  char_lcd_nibble_sequencer_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .value_i         (value_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .glyph_slot_i    (glyph_slot_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .reg_select_o    (reg_select_o),
    .nibble_o        (nibble_o),
    .wait_before_us_o(wait_before_us_o),
    .wait_after_us_o (wait_after_us_o),
    .last_o          (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic void push_strobe(logic rs, logic [3:0] nib, logic [15:0] pre_wait,
                                      logic [12:0] after);
    lcd_strobe_t s;
    s = '{rs: rs, nibble: nib, wait_before: pre_wait, wait_after: after, last: 1'b0};
    pending_strobes.push_back(s);
  endfunction

  // high nibble first, extra hold only on the low one
  function automatic void push_byte(logic rs, logic [7:0] b, logic [12:0] extra);
    push_strobe(rs, b[7:4], 16'd0, HOLD_US);
    push_strobe(rs, b[3:0], 16'd0, HOLD_US + extra);
  endfunction

  function automatic void expand_op(logic [2:0] cmd, logic [7:0] val, logic row,
                                    logic [5:0] col, logic [2:0] slot);
    int unsigned n_before;
    logic [7:0]  addr;
    n_before = pending_strobes.size();
    case (cmd)
      CMD_INIT: begin
        push_strobe(1'b0, WAKE_NIBBLE, WAKE_FIRST_US, HOLD_US);
        push_strobe(1'b0, WAKE_NIBBLE, WAKE_NEXT_US, HOLD_US);
        push_strobe(1'b0, WAKE_NIBBLE, WAKE_NEXT_US, HOLD_US);
        push_strobe(1'b0, MODE4_NIBBLE, WAKE_LAST_US, HOLD_US);
        push_byte(1'b0, FUNC_SET_BYTE, 13'd0);
        push_byte(1'b0, DISPLAY_ON_BYTE, 13'd0);
        push_byte(1'b0, ENTRY_MODE_BYTE, 13'd0);
        push_byte(1'b0, CLEAR_BYTE, CLEAR_EXTRA_US);
      end
      CMD_INSTR: push_byte(1'b0, val, 13'd0);
      CMD_DATA:  push_byte(1'b1, val, 13'd0);
      CMD_CLEAR: push_byte(1'b0, CLEAR_BYTE, CLEAR_EXTRA_US);
      CMD_POS: begin
        addr = ((row ? SECOND_LINE : 8'h00) + {2'b00, col}) & 8'h7F;
        push_byte(1'b0, SET_DDRAM_BIT | addr, 13'd0);
      end
      CMD_GLYPH: push_byte(1'b0, SET_CGRAM_BIT | {2'b00, slot, 3'b000}, 13'd0);
      default: ;
    endcase
    if (pending_strobes.size() > n_before)
      pending_strobes[pending_strobes.size() - 1].last = 1'b1;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    lcd_strobe_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_strobes.size() == 0) begin
        $display("%0t: unexpected strobe, expected none, actual rs %0d nibble %0h last %0d",
                 $time, reg_select_o, nibble_o, last_o);
        mismatch_count++;
      end else begin
        want = pending_strobes.pop_front();
        check_field("reg_select", want.rs, reg_select_o);
        check_field("nibble", want.nibble, nibble_o);
        check_field("wait_before_us", want.wait_before, wait_before_us_o);
        check_field("wait_after_us", want.wait_after, wait_after_us_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  // valid is left high after acceptance; the next call or the drain decides
  task automatic send_op(logic [2:0] cmd, logic [7:0] val, logic row, logic [5:0] col,
                         logic [2:0] slot);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < in_idle_pct) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    value_i      <= val;
    row_i        <= row;
    col_i        <= col;
    glyph_slot_i <= slot;
    do @(posedge clk_i); while (!in_ready_o);
    expand_op(cmd, val, row, col, slot);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_strobes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly single-byte commands, some inits, a few dropped codes
  task automatic random_ops(int unsigned count);
    int unsigned sent;
    int unsigned pick;
    logic [2:0]  cmd;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 8) cmd = CMD_INIT;
      else if (pick < 14) cmd = ($urandom_range(1) != 0) ? CMD_SPARE_B : CMD_SPARE_A;
      else cmd = 3'($urandom_range(CMD_GLYPH, CMD_INSTR));
      send_op(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)), 6'($urandom_range(63)),
              3'($urandom_range(7)));
      if (cmd <= CMD_GLYPH) sent++;
    end
  endtask

  task automatic test_directed_cases();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_op(CMD_INIT, 8'h00, 1'b0, 6'd0, 3'd0);
    send_op(CMD_INSTR, 8'h00, 1'b0, 6'd0, 3'd0);
    send_op(CMD_INSTR, 8'hFF, 1'b1, 6'd63, 3'd7);
    send_op(CMD_DATA, 8'h00, 1'b0, 6'd0, 3'd0);
    send_op(CMD_DATA, 8'hFF, 1'b1, 6'd63, 3'd7);
    send_op(CMD_DATA, 8'hA5, 1'b0, 6'd21, 3'd2);
    send_op(CMD_CLEAR, 8'hFF, 1'b1, 6'd63, 3'd7);
    send_op(CMD_POS, 8'h00, 1'b0, 6'd0, 3'd0);
    send_op(CMD_POS, 8'hFF, 1'b1, 6'd39, 3'd0);
    // columns past the visible line are passed through unchecked
    send_op(CMD_POS, 8'h00, 1'b1, 6'd63, 3'd7);
    send_op(CMD_POS, 8'h00, 1'b0, 6'd63, 3'd0);
    send_op(CMD_POS, 8'h00, 1'b0, 6'd40, 3'd0);
    send_op(CMD_GLYPH, 8'hFF, 1'b1, 6'd63, 3'd0);
    send_op(CMD_GLYPH, 8'h00, 1'b0, 6'd0, 3'd7);
    // dropped codes in between real ones
    send_op(CMD_SPARE_A, 8'hFF, 1'b1, 6'd63, 3'd7);
    send_op(CMD_INSTR, 8'h5A, 1'b0, 6'd0, 3'd0);
    send_op(CMD_SPARE_B, 8'h00, 1'b0, 6'd0, 3'd0);
    send_op(CMD_INIT, 8'hFF, 1'b1, 6'd63, 3'd7);
    send_op(CMD_CLEAR, 8'h00, 1'b0, 6'd0, 3'd0);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    random_ops(RANDOM_OPS);
    wait_drained();
  endtask

  task automatic test_sparse_input();
    in_idle_pct   = 77;
    out_stall_pct = 0;
    random_ops(RANDOM_OPS);
    wait_drained();
  endtask

  task automatic test_slow_output();
    in_idle_pct   = 0;
    out_stall_pct = 77;
    random_ops(RANDOM_OPS);
    wait_drained();
  endtask

  task automatic test_mixed_idle();
    in_idle_pct   = 10;
    out_stall_pct = 10;
    random_ops(RANDOM_OPS);
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_back_to_back();
    test_sparse_input();
    test_slow_output();
    test_mixed_idle();
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
